// File: design/bmg_pkg.sv
`default_nettype none

package bmg_pkg;

  // Precision of the uniform inputs; low bits beyond it are cleared.
  localparam int UNIFORM_BITS = 32;
  localparam int USED_BITS    = (UNIFORM_BITS < 32) ? UNIFORM_BITS : 32;
  localparam int DROP_BITS    = 32 - USED_BITS;
  localparam logic [31:0] KEEP_MASK = (32'hFFFF_FFFF >> DROP_BITS) << DROP_BITS;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MEAN  = 2'd0;
  localparam logic [1:0] CFG_SIGMA = 2'd1;

  localparam logic [23:0] SIGMA_RESET = 24'd65536;

  // Arithmetic constants.
  localparam int          LOG_STEPS    = 26;
  localparam int          SQRT_STEPS   = 30;
  localparam int          CORDIC_STEPS = 28;
  localparam logic [31:0] TWO_LN2_Q30  = 32'd1488522236;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
  } bmg_in_t;

  typedef struct packed {
    logic signed [31:0] cosine_sample;
    logic signed [31:0] sine_sample;
    logic               saturated;
  } bmg_out_t;

endpackage

`default_nettype wire

// File: design/box_muller_gaussian_generator_core.sv
`default_nettype none

// Gaussian noise generator built on the Box-Muller transform.
// A request is accepted at a rising edge with start high and busy low; busy
// is always low, so a new pair of uniform fractions may enter every cycle.
// Each request yields exactly one result: done_o is high for one cycle while
// result_o holds mean + sigma*r*cos and mean + sigma*r*sin in signed Q16.16,
// with a flag set when either sample was clipped. The receiver cannot hold
// results off, and none is needed: nothing inside ever waits.
// The datapath runs through the 26-stage squaring log2, the 30-stage square
// root and the 28-stage CORDIC, each stage holding one multiplier or one
// wide add and compare. Throughput is one result per cycle.
// Mean and standard deviation are written through the plain write port and
// should only change while no request is in flight. Reset clears all valid
// bits and sets mean to 0 and sigma to 1.0.
module box_muller_gaussian_generator_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bmg_pkg::bmg_in_t  req_i,
  output logic                   done_o,
  output bmg_pkg::bmg_out_t      result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i
);
  import bmg_pkg::*;

  // Configuration registers.
  logic signed [31:0] mean_q;
  logic [23:0]        sigma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      sigma_q <= SIGMA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEAN:  mean_q  <= cfg_data_i;
        CFG_SIGMA: sigma_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic        acc;
  logic [31:0] u1;
  logic [31:0] u2;

  assign acc = start && !busy;
  assign u1  = req_i.uniform_radius & KEEP_MASK;
  assign u2  = req_i.uniform_angle & KEEP_MASK;

  // Radius from the first fraction.
  logic        rad_vld;
  logic [29:0] rad;
  logic [31:0] rad_ang;

  bmg_radius u_radius (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (acc),
    .u1_i     (u1),
    .tag_i    (u2),
    .valid_o  (rad_vld),
    .radius_o (rad),
    .tag_o    (rad_ang)
  );

  // Rotation by the angle from the second fraction.
  logic               rot_vld;
  logic signed [32:0] rot_c;
  logic signed [32:0] rot_s;

  bmg_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rad_vld),
    .radius_i (rad),
    .angle_i  (rad_ang),
    .valid_o  (rot_vld),
    .cos_o    (rot_c),
    .sin_o    (rot_s)
  );

  // Scale by sigma.
  logic signed [24:0] sigma_s;
  logic               p_vld_q;
  logic signed [57:0] pc_q;
  logic signed [57:0] ps_q;

  assign sigma_s = {1'b0, sigma_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= rot_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= 58'(sigma_s) * 58'(rot_c);
    ps_q <= 58'(sigma_s) * 58'(rot_s);
  end

  // Round, add the mean and clamp.
  logic signed [57:0] rc;
  logic signed [57:0] rs;
  logic signed [33:0] sum_c;
  logic signed [33:0] sum_s;
  logic signed [33:0] mean_x;
  logic signed [31:0] out_c;
  logic signed [31:0] out_s;
  logic               sat_c;
  logic               sat_s;

  localparam logic signed [33:0] MAX_S = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] MIN_S = -34'sh0_8000_0000;

  always_comb begin
    rc     = (pc_q + 58'sd67108864) >>> 27;
    rs     = (ps_q + 58'sd67108864) >>> 27;
    mean_x = {{2{mean_q[31]}}, mean_q};
    sum_c  = {{3{rc[30]}}, rc[30:0]} + mean_x;
    sum_s  = {{3{rs[30]}}, rs[30:0]} + mean_x;
    sat_c  = 1'b1;
    sat_s  = 1'b1;
    if (sum_c > MAX_S) begin
      out_c = 32'sh7FFF_FFFF;
    end else if (sum_c < MIN_S) begin
      out_c = 32'sh8000_0000;
    end else begin
      out_c = sum_c[31:0];
      sat_c = 1'b0;
    end
    if (sum_s > MAX_S) begin
      out_s = 32'sh7FFF_FFFF;
    end else if (sum_s < MIN_S) begin
      out_s = 32'sh8000_0000;
    end else begin
      out_s = sum_s[31:0];
      sat_s = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.cosine_sample <= out_c;
    result_o.sine_sample   <= out_s;
    result_o.saturated     <= sat_c | sat_s;
  end

endmodule

`default_nettype wire

// File: design/bmg_radius.sv
`default_nettype none

module bmg_radius (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] u1_i,
  input  wire logic [31:0] tag_i,
  output logic             valid_o,
  output logic [29:0]      radius_o,
  output logic [31:0]      tag_o
);
  import bmg_pkg::*;

  // Stage 1: v = 2^32 - u1.
  logic        v_vld_q;
  logic [32:0] v_q;
  logic [31:0] v_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
    end else begin
      v_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= 33'h1_0000_0000 - {1'b0, u1_i};
    v_tag_q <= tag_i;
  end

  // Stage 2: position of the leading one.
  logic [5:0]  e_d;
  logic        e_vld_q;
  logic [5:0]  e_q;
  logic [32:0] ev_q;
  logic [31:0] e_tag_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (v_q[i]) e_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    ev_q    <= v_q;
    e_tag_q <= v_tag_q;
  end

  // Stage 3: normalize to Q1.30 in [1,2).
  logic [63:0] vw;
  logic [30:0] m_d;

  always_comb begin
    vw = {31'b0, ev_q};
    if (e_q <= 6'd30) begin
      m_d = 31'(vw << (6'd30 - e_q));
    end else begin
      m_d = 31'(vw >> (e_q - 6'd30));
    end
  end

  // Squaring pipeline, one fraction bit of log2 per stage.
  logic        lg_vld_q  [LOG_STEPS+1];
  logic [30:0] lg_m_q    [LOG_STEPS+1];
  logic [25:0] lg_frac_q [LOG_STEPS+1];
  logic [5:0]  lg_e_q    [LOG_STEPS+1];
  logic [31:0] lg_tag_q  [LOG_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_vld_q[0] <= 1'b0;
    end else begin
      lg_vld_q[0] <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lg_m_q[0]    <= m_d;
    lg_frac_q[0] <= '0;
    lg_e_q[0]    <= e_q;
    lg_tag_q[0]  <= e_tag_q;
  end

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [61:0] sq;
    logic [31:0] t;
    logic [30:0] m_nx;
    logic [25:0] f_nx;

    always_comb begin
      sq   = 62'(lg_m_q[k]) * 62'(lg_m_q[k]);
      t    = sq[61:30];
      f_nx = lg_frac_q[k];
      if (t[31]) begin
        m_nx = t[31:1];
        f_nx[LOG_STEPS-1-k] = 1'b1;
      end else begin
        m_nx = t[30:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_vld_q[k+1] <= 1'b0;
      end else begin
        lg_vld_q[k+1] <= lg_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      lg_m_q[k+1]    <= m_nx;
      lg_frac_q[k+1] <= f_nx;
      lg_e_q[k+1]    <= lg_e_q[k];
      lg_tag_q[k+1]  <= lg_tag_q[k];
    end
  end

  // -log2(1-u1) in Q6.26.
  logic        len_vld_q;
  logic [31:0] len_q;
  logic [31:0] len_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= 1'b0;
    end else begin
      len_vld_q <= lg_vld_q[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= 32'h8000_0000 -
                 ({lg_e_q[LOG_STEPS], 26'b0} + {6'b0, lg_frac_q[LOG_STEPS]});
    len_tag_q <= lg_tag_q[LOG_STEPS];
  end

  // Scale by 2 ln 2 to get r^2 in Q.30.
  logic [63:0] r2_prod;
  logic        r2_vld_q;
  logic [35:0] r2_q;
  logic [31:0] r2_tag_q;

  assign r2_prod = 64'(len_q) * 64'(TWO_LN2_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_vld_q <= 1'b0;
    end else begin
      r2_vld_q <= len_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q     <= r2_prod[61:26];
    r2_tag_q <= len_tag_q;
  end

  // Square root, one result bit per stage.
  logic        sq_vld_q [SQRT_STEPS+1];
  logic [59:0] sq_a_q   [SQRT_STEPS+1];
  logic [59:0] sq_res_q [SQRT_STEPS+1];
  logic [31:0] sq_tag_q [SQRT_STEPS+1];

  assign sq_vld_q[0] = r2_vld_q;
  assign sq_a_q[0]   = {r2_q, 24'b0};
  assign sq_res_q[0] = '0;
  assign sq_tag_q[0] = r2_tag_q;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int BIT_POS = 2 * (SQRT_STEPS - 1 - j);
    logic [59:0] trial;
    logic [59:0] a_nx;
    logic [59:0] res_nx;

    always_comb begin
      trial = sq_res_q[j] + (60'd1 << BIT_POS);
      if (sq_a_q[j] >= trial) begin
        a_nx   = sq_a_q[j] - trial;
        res_nx = (sq_res_q[j] >> 1) + (60'd1 << BIT_POS);
      end else begin
        a_nx   = sq_a_q[j];
        res_nx = sq_res_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_a_q[j+1]   <= a_nx;
      sq_res_q[j+1] <= res_nx;
      sq_tag_q[j+1] <= sq_tag_q[j];
    end
  end

  assign valid_o  = sq_vld_q[SQRT_STEPS];
  assign radius_o = sq_res_q[SQRT_STEPS][29:0];
  assign tag_o    = sq_tag_q[SQRT_STEPS];

endmodule

`default_nettype wire

// File: design/bmg_cordic.sv
`default_nettype none

module bmg_cordic (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [29:0] radius_i,
  input  wire logic [31:0] angle_i,
  output logic             valid_o,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);
  import bmg_pkg::*;

  // Gain-compensated start vector.
  logic [63:0] x0_prod;
  assign x0_prod = 64'(radius_i) * 64'(INV_GAIN_Q32);

  logic               cr_vld_q  [CORDIC_STEPS+1];
  logic signed [32:0] cr_x_q    [CORDIC_STEPS+1];
  logic signed [32:0] cr_y_q    [CORDIC_STEPS+1];
  logic signed [32:0] cr_z_q    [CORDIC_STEPS+1];
  logic [1:0]         cr_quad_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_vld_q[0] <= 1'b0;
    end else begin
      cr_vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_x_q[0]    <= {1'b0, x0_prod[63:32]};
    cr_y_q[0]    <= '0;
    cr_z_q[0]    <= {3'b0, angle_i[29:0]};
    cr_quad_q[0] <= angle_i[31:30];
  end

  // One rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] ang;
    logic signed [32:0] x_nx;
    logic signed [32:0] y_nx;
    logic signed [32:0] z_nx;

    always_comb begin
      dx  = cr_y_q[i] >>> i;
      dy  = cr_x_q[i] >>> i;
      ang = {1'b0, ATAN_TURN[i]};
      if (!cr_z_q[i][32]) begin
        x_nx = cr_x_q[i] - dx;
        y_nx = cr_y_q[i] + dy;
        z_nx = cr_z_q[i] - ang;
      end else begin
        x_nx = cr_x_q[i] + dx;
        y_nx = cr_y_q[i] - dy;
        z_nx = cr_z_q[i] + ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cr_vld_q[i+1] <= 1'b0;
      end else begin
        cr_vld_q[i+1] <= cr_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      cr_x_q[i+1]    <= x_nx;
      cr_y_q[i+1]    <= y_nx;
      cr_z_q[i+1]    <= z_nx;
      cr_quad_q[i+1] <= cr_quad_q[i];
    end
  end

  // Quadrant mapping.
  logic signed [32:0] xf;
  logic signed [32:0] yf;
  logic signed [32:0] c_d;
  logic signed [32:0] s_d;
  logic               q_vld_q;
  logic signed [32:0] c_q;
  logic signed [32:0] s_q;

  assign xf = cr_x_q[CORDIC_STEPS];
  assign yf = cr_y_q[CORDIC_STEPS];

  always_comb begin
    case (cr_quad_q[CORDIC_STEPS])
      2'd1: begin
        c_d = -yf;
        s_d = xf;
      end
      2'd2: begin
        c_d = -xf;
        s_d = -yf;
      end
      2'd3: begin
        c_d = yf;
        s_d = -xf;
      end
      default: begin
        c_d = xf;
        s_d = yf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else begin
      q_vld_q <= cr_vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    s_q <= s_d;
  end

  assign valid_o = q_vld_q;
  assign cos_o   = c_q;
  assign sin_o   = s_q;

endmodule

`default_nettype wire
